// ----- src/dcwq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcwq_pkg
// Shared types and constants of the duplicate-rejecting circular work queue.
// ----------------------------------------------------------------------------
package dcwq_pkg;

  // storage geometry
  localparam int unsigned DEPTH     = 1024;
  localparam int unsigned ITEM_BITS = 16;
  localparam int unsigned PTR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = PTR_W + 1;

  // configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  // register index, taken from the word address
  typedef enum logic {
    REG_CAPACITY = 1'b0
  } reg_idx_e;

  typedef logic [CNT_W-1:0] cap_t;

  // result codes
  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_POPPED  = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  // request kinds
  typedef enum logic {
    REQ_ADD = 1'b0,
    REQ_POP = 1'b1
  } req_e;

endpackage

// ----- src/dcwq_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcwq_cfg
// Configuration register file: holds the capacity register and provides the
// clamped capacity (1 to DEPTH) that the queue pointers wrap at.
// ----------------------------------------------------------------------------
module dcwq_cfg import dcwq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cap_t              cap_o
);

  logic [CNT_W-1:0] capacity_q, capacity_d;
  reg_idx_e         reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;

  // register write
  always_comb begin
    capacity_d = capacity_q;
    if (wr_en && reg_idx == REG_CAPACITY) begin
      capacity_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else begin
      capacity_q <= capacity_d;
    end
  end

  // register read
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_CAPACITY: prdata = APB_DW'(capacity_q);
      default:      prdata = '0;
    endcase
  end

  // clamp to the usable range
  always_comb begin
    if (capacity_q == '0) begin
      cap_o = CNT_W'(1);
    end else if (capacity_q > CNT_W'(DEPTH)) begin
      cap_o = CNT_W'(DEPTH);
    end else begin
      cap_o = capacity_q;
    end
  end

endmodule

// ----- src/dedup_circular_work_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_circular_work_queue
// Circular FIFO of item numbers that refuses duplicates. An add scans the
// live entries from head to tail before writing at the tail; a pop returns
// the head entry. Every transaction yields one result with the item count.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | tdata: item_value; tuser: req_type
//  m_axis   | out       | tdata: popped_value, item_count; tuser: status
//  apb      | in/out    | capacity register at byte address 0
//
//  an add reads one slot per live entry, compares each read with the item
//  and then decides (no slot is read when the queue is empty); a match
//  ends the scan early; a pop makes one memory read of the head slot, and
//  a pop of an empty queue reads no slot
//  reset clears pointers and count; slot contents stay unwritten, no clearing
//  a new transaction is taken while a result waits in the output register;
//  the next result waits until that register is emptied
// ----------------------------------------------------------------------------
module dedup_circular_work_queue import dcwq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [15:0] item_value
  input  logic              s_axis_tuser,   // [0] req_type
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // [15:0] popped_value, [26:16] item_count
  output logic [2:0]        m_axis_tuser,   // [2:0] status
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_POP    = 4'b0100,
    S_RESULT = 4'b1000
  } state_e;

  cap_t cap;

  dcwq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  // control state
  state_e                state_q, state_d;
  logic [PTR_W-1:0]      head_q, head_d;
  logic [PTR_W-1:0]      tail_q, tail_d;
  logic [CNT_W-1:0]      fill_q, fill_d;
  logic [PTR_W-1:0]      scan_ptr_q, scan_ptr_d;
  logic [CNT_W-1:0]      issued_q, issued_d;
  logic                  rd_vld_q, rd_vld_d;
  logic                  m_valid_q, m_valid_d;
  // payload
  logic [ITEM_BITS-1:0]  item_q, item_d;
  status_e               res_status_q, res_status_d;
  logic [ITEM_BITS-1:0]  res_pop_q, res_pop_d;
  logic [CNT_W-1:0]      res_cnt_q, res_cnt_d;
  status_e               out_status_q, out_status_d;
  logic [ITEM_BITS-1:0]  out_pop_q, out_pop_d;
  logic [CNT_W-1:0]      out_cnt_q, out_cnt_d;

  // slot memory
  logic [ITEM_BITS-1:0]  mem [DEPTH];
  logic [ITEM_BITS-1:0]  rdata_q;
  logic                  mem_re, mem_we;
  logic [PTR_W-1:0]      mem_raddr;

  logic                  in_acc;
  logic                  out_free;
  logic                  hit;
  logic                  scan_issue;

  function automatic logic [PTR_W-1:0] advance(logic [PTR_W-1:0] p, cap_t c);
    logic [CNT_W-1:0] n;
    n = CNT_W'(p) + CNT_W'(1);
    return (n >= c) ? '0 : n[PTR_W-1:0];
  endfunction

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_valid_q | m_axis_tready;
  assign hit           = rd_vld_q && (rdata_q == item_q);
  assign scan_issue    = (state_q == S_SCAN) && (issued_q != fill_q) && !hit;

  // memory ports: reads during the scan or for a pop, write on a successful add
  assign mem_re    = scan_issue ||
                     (in_acc && req_e'(s_axis_tuser) == REQ_POP && fill_q != '0);
  assign mem_raddr = (state_q == S_SCAN) ? scan_ptr_q : head_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_q] <= item_q;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    fill_d       = fill_q;
    scan_ptr_d   = scan_ptr_q;
    issued_d     = issued_q;
    rd_vld_d     = 1'b0;
    item_d       = item_q;
    res_status_d = res_status_q;
    res_pop_d    = res_pop_q;
    res_cnt_d    = res_cnt_q;
    mem_we       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          item_d = s_axis_tdata[ITEM_BITS-1:0];
          if (req_e'(s_axis_tuser) == REQ_ADD) begin
            scan_ptr_d = head_q;
            issued_d   = '0;
            state_d    = S_SCAN;
          end else if (fill_q == '0) begin
            res_status_d = ST_EMPTY;
            res_pop_d    = '0;
            res_cnt_d    = fill_q;
            state_d      = S_RESULT;
          end else begin
            state_d = S_POP;
          end
        end
      end
      S_SCAN: begin
        if (scan_issue) begin
          scan_ptr_d = advance(scan_ptr_q, cap);
          issued_d   = issued_q + CNT_W'(1);
          rd_vld_d   = 1'b1;
        end
        res_pop_d = '0;
        if (hit) begin
          res_status_d = ST_PRESENT;
          res_cnt_d    = fill_q;
          state_d      = S_RESULT;
        end else if (issued_q == fill_q && !rd_vld_q) begin
          if (fill_q >= cap) begin
            res_status_d = ST_FULL;
            res_cnt_d    = fill_q;
          end else begin
            mem_we       = 1'b1;
            tail_d       = advance(tail_q, cap);
            fill_d       = fill_q + CNT_W'(1);
            res_status_d = ST_ADDED;
            res_cnt_d    = fill_q + CNT_W'(1);
          end
          state_d = S_RESULT;
        end
      end
      S_POP: begin
        head_d       = advance(head_q, cap);
        fill_d       = fill_q - CNT_W'(1);
        res_status_d = ST_POPPED;
        res_pop_d    = rdata_q;
        res_cnt_d    = fill_q - CNT_W'(1);
        state_d      = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    m_valid_d    = m_valid_q & ~m_axis_tready;
    out_status_d = out_status_q;
    out_pop_d    = out_pop_q;
    out_cnt_d    = out_cnt_q;
    if (state_q == S_RESULT && out_free) begin
      m_valid_d    = 1'b1;
      out_status_d = res_status_q;
      out_pop_d    = res_pop_q;
      out_cnt_d    = res_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      fill_q     <= '0;
      scan_ptr_q <= '0;
      issued_q   <= '0;
      rd_vld_q   <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      fill_q     <= fill_d;
      scan_ptr_q <= scan_ptr_d;
      issued_q   <= issued_d;
      rd_vld_q   <= rd_vld_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    res_status_q <= res_status_d;
    res_pop_q    <= res_pop_d;
    res_cnt_q    <= res_cnt_d;
    out_status_q <= out_status_d;
    out_pop_q    <= out_pop_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {(32 - CNT_W - ITEM_BITS)'(0), out_cnt_q, out_pop_q};

endmodule
